FILE: rtl/edd_pkg.sv
// shared constants and types for the euclidean distance block
// no dependencies; used by every module of the block by scoped names
package edd_pkg;

    localparam int COORD_WIDTH   = 24;
    localparam int MAX_DIMENSION = 16;
    localparam int DIM_W         = 5;
    localparam int CNT_W         = 5;
    localparam int MAG_W         = COORD_WIDTH + 1;
    localparam int SQ_W          = 2 * MAG_W;
    localparam int SUM_W         = 54;
    localparam int DIST_W        = 27;
    localparam int REM_W         = DIST_W + 2;
    localparam int ITER_W        = 5;
    localparam int Q_DEPTH       = 2;
    localparam int QPTR_W        = 1;
    localparam int QCNT_W        = 2;
    localparam int ADDR_W        = 3;
    localparam int DATA_W        = 32;

    localparam logic [DIM_W-1:0] DIM_RESET = 5'd1;
    localparam logic             REG_DIMENSION = 1'b0;

    typedef struct packed {
        logic             valid;
        logic [SUM_W-1:0] sum;
    } edd_req_t;

endpackage

FILE: rtl/edd_front.sv
// front part: takes coordinate pairs, squares the difference and accumulates
// depends on edd_pkg; pushes each finished sum of squares to the queue
module edd_front (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic signed [edd_pkg::COORD_WIDTH-1:0]  coord_a,
    input  logic signed [edd_pkg::COORD_WIDTH-1:0]  coord_b,
    input  logic        [edd_pkg::DIM_W-1:0]        dimension,
    output edd_pkg::edd_req_t                       push,
    input  logic                                    push_ready
);

    logic [edd_pkg::CNT_W-1:0]  cnt_reg, cnt_next, cnt_plus;
    logic [edd_pkg::DIM_W-1:0]  eff_dim;
    logic                       in_last;
    logic signed [edd_pkg::MAG_W-1:0] diff;
    logic [edd_pkg::MAG_W-1:0]  mag;

    logic                       a_valid_reg, a_last_reg;
    logic [edd_pkg::MAG_W-1:0]  a_mag_reg;
    logic                       b_valid_reg, b_last_reg;
    logic [edd_pkg::SQ_W-1:0]   b_sq_reg;
    logic [edd_pkg::SUM_W-1:0]  acc_reg, acc_next;
    logic [edd_pkg::SUM_W:0]    wide_sum;
    logic [edd_pkg::SUM_W-1:0]  sum_new;
    logic                       stall, advance, take;

    always_comb
    begin
        if (dimension == '0)
            eff_dim = edd_pkg::DIM_W'(1);
        else if (dimension > edd_pkg::DIM_W'(edd_pkg::MAX_DIMENSION))
            eff_dim = edd_pkg::DIM_W'(edd_pkg::MAX_DIMENSION);
        else
            eff_dim = dimension;
    end

    assign cnt_plus = cnt_reg + edd_pkg::CNT_W'(1);
    assign in_last  = cnt_plus >= edd_pkg::CNT_W'(eff_dim);
    assign cnt_next = in_last ? '0 : cnt_plus;

    assign diff = {coord_a[edd_pkg::COORD_WIDTH-1], coord_a}
                - {coord_b[edd_pkg::COORD_WIDTH-1], coord_b};
    assign mag  = diff[edd_pkg::MAG_W-1] ? edd_pkg::MAG_W'(-diff) : edd_pkg::MAG_W'(diff);

    // saturating accumulate of the squared difference
    assign wide_sum = {1'b0, acc_reg} + {{(edd_pkg::SUM_W + 1 - edd_pkg::SQ_W){1'b0}}, b_sq_reg};
    assign sum_new  = wide_sum[edd_pkg::SUM_W] ? '1 : wide_sum[edd_pkg::SUM_W-1:0];

    assign stall    = b_valid_reg && b_last_reg && !push_ready;
    assign advance  = !stall;
    assign in_ready = advance;
    assign take     = in_valid && in_ready;

    assign push.valid = b_valid_reg && b_last_reg;
    assign push.sum   = sum_new;

    always_comb
    begin
        acc_next = acc_reg;
        if (advance && b_valid_reg)
            acc_next = b_last_reg ? '0 : sum_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            acc_reg     <= '0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg <= acc_next;
            if (take)
                cnt_reg <= cnt_next;
            if (advance)
            begin
                a_valid_reg <= take;
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_mag_reg  <= mag;
            a_last_reg <= in_last;
            b_sq_reg   <= a_mag_reg * a_mag_reg;
            b_last_reg <= a_last_reg;
        end
    end

endmodule

FILE: rtl/edd_fifo.sv
// short queue of finished sums of squares between front and back parts
// depends on edd_pkg for widths and the request type
module edd_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  edd_pkg::edd_req_t  push,
    output logic               push_ready,
    output edd_pkg::edd_req_t  pop,
    input  logic               pop_ready
);

    logic [edd_pkg::SUM_W-1:0]  mem_reg [edd_pkg::Q_DEPTH];
    logic [edd_pkg::QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [edd_pkg::QCNT_W-1:0] count_reg, count_next;
    logic                       do_push, do_pop;

    assign push_ready = count_reg != edd_pkg::QCNT_W'(edd_pkg::Q_DEPTH);
    assign pop.valid  = count_reg != '0;
    assign pop.sum    = mem_reg[rd_ptr_reg];
    assign do_push    = push.valid && push_ready;
    assign do_pop     = pop.valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + edd_pkg::QCNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - edd_pkg::QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + edd_pkg::QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + edd_pkg::QPTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push.sum;
    end

endmodule

FILE: rtl/edd_sqrt.sv
// back part: bit-serial integer square root, one root bit per cycle
// depends on edd_pkg; holds the result in an output register
module edd_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  edd_pkg::edd_req_t             pop,
    output logic                          pop_ready,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [edd_pkg::DIST_W-1:0]    dist_value
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]                  state_reg, state_next;
    logic [edd_pkg::ITER_W-1:0]  iter_reg;
    logic [edd_pkg::SUM_W-1:0]   rad_reg;
    logic [edd_pkg::REM_W-1:0]   rem_reg, rem_shift, trial, rem_next;
    logic [edd_pkg::DIST_W-1:0]  root_reg, root_next;
    logic                        out_valid_reg;
    logic [edd_pkg::DIST_W-1:0]  dist_value_reg;
    logic                        out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign pop_ready = state_reg == S_IDLE;

    assign rem_shift = {rem_reg[edd_pkg::REM_W-3:0], rad_reg[edd_pkg::SUM_W-1 -: 2]};
    assign trial     = {root_reg, 2'b01};

    always_comb
    begin
        if (rem_shift >= trial)
        begin
            rem_next  = rem_shift - trial;
            root_next = {root_reg[edd_pkg::DIST_W-2:0], 1'b1};
        end
        else
        begin
            rem_next  = rem_shift;
            root_next = {root_reg[edd_pkg::DIST_W-2:0], 1'b0};
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (pop.valid)
                    state_next = S_RUN;
            S_RUN:
                if (iter_reg == '0)
                    state_next = S_DONE;
            S_DONE:
                if (out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && pop.valid)
        begin
            rad_reg  <= pop.sum;
            rem_reg  <= '0;
            root_reg <= '0;
            iter_reg <= edd_pkg::ITER_W'(edd_pkg::DIST_W - 1);
        end
        else if (state_reg == S_RUN)
        begin
            rad_reg  <= {rad_reg[edd_pkg::SUM_W-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
            iter_reg <= iter_reg - edd_pkg::ITER_W'(1);
        end
        if (state_reg == S_DONE && out_free)
            dist_value_reg <= root_reg;
    end

    assign out_valid  = out_valid_reg;
    assign dist_value = dist_value_reg;

endmodule

FILE: rtl/euclidean_distance.sv
// euclidean distance top level: register port, front part, queue, root unit
// depends on edd_pkg, edd_front, edd_fifo and edd_sqrt
// one request accepted per cycle unless the queue is full; out_valid rises after the
// last component passes the square stage, queue write and pop, 27 root steps and
// output register; the shift-subtract root takes no new sum until its result is out,
// bounding results at low dimension; reset clears sum, count, queue, dimension to 1
module euclidean_distance (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [edd_pkg::ADDR_W-1:0]              paddr,
    input  logic [edd_pkg::DATA_W-1:0]              pwdata,
    output logic [edd_pkg::DATA_W-1:0]              prdata,
    output logic                                    pready,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic signed [edd_pkg::COORD_WIDTH-1:0]  coord_a,
    input  logic signed [edd_pkg::COORD_WIDTH-1:0]  coord_b,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [edd_pkg::DIST_W-1:0]              dist_value
);

    logic [edd_pkg::DIM_W-1:0] dimension_reg;
    logic                      reg_sel;
    edd_pkg::edd_req_t         q_push, q_pop;
    logic                      q_push_ready, q_pop_ready;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2] == edd_pkg::REG_DIMENSION;
    assign prdata  = reg_sel ? {{(edd_pkg::DATA_W - edd_pkg::DIM_W){1'b0}}, dimension_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dimension_reg <= edd_pkg::DIM_RESET;
        else if (psel && penable && pwrite && pready && reg_sel)
            dimension_reg <= pwdata[edd_pkg::DIM_W-1:0];
    end

    edd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .coord_a    (coord_a),
        .coord_b    (coord_b),
        .dimension  (dimension_reg),
        .push       (q_push),
        .push_ready (q_push_ready)
    );

    edd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_ready (q_push_ready),
        .pop        (q_pop),
        .pop_ready  (q_pop_ready)
    );

    edd_sqrt u_sqrt (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop        (q_pop),
        .pop_ready  (q_pop_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .dist_value (dist_value)
    );

    a_push_held: assert property (@(posedge clk) disable iff (!rst_n)
        q_push.valid && !q_push_ready |=> q_push.valid)
        else $error("stalled sum dropped by front part");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> q_push.valid && !q_push_ready)
        else $error("request refused without a full queue");

    a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(q_pop.valid) |-> $past(q_pop_ready))
        else $error("queue emptied without a pop");

endmodule
